@@ hw/rtl/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, operation codes and structures of the LFU tag store.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 16;
    localparam int CAP_BITS   = 4;
    localparam int SLOT_BITS  = $clog2(ENTRIES);
    localparam int RANK_BITS  = SLOT_BITS;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);
    localparam int CMP_BITS   = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

    localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(8);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [1:0] t_op;
    localparam t_op OP_NONE    = 2'd0;
    localparam t_op OP_HIT     = 2'd1;
    localparam t_op OP_INSERT  = 2'd2;
    localparam t_op OP_REPLACE = 2'd3;

    // Update broadcast to every cell.
    typedef struct packed {
        t_op                   op;
        logic [SLOT_BITS-1:0]  idx;
        logic [RANK_BITS-1:0]  rank;
        logic [KEY_BITS-1:0]   key;
    } t_cmd;

    // Best eviction candidate so far, handed from cell to cell.
    typedef struct packed {
        logic                  found;
        logic [SLOT_BITS-1:0]  idx;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_BITS-1:0]  rank;
        logic [KEY_BITS-1:0]   tag;
    } t_cand;

    // What one cell reports for lookup.
    typedef struct packed {
        logic                  valid;
        logic                  match;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_BITS-1:0]  rank;
    } t_stat;

endpackage

@@ hw/rtl/lfu_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cell
// One entry of the tag store with its stage of the victim search chain.
// ----------------------------------------------------------------------------
module lfu_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lfu_pkg::SLOT_BITS-1:0]    i_index,
    input  lfu_pkg::t_cmd                    i_cmd,
    input  lfu_pkg::t_cand                   i_cand,
    output lfu_pkg::t_cand                   o_cand,
    output lfu_pkg::t_stat                   o_stat
);

    logic                              r_valid, n_valid;
    logic [lfu_pkg::KEY_BITS-1:0]      r_tag, n_tag;
    logic [lfu_pkg::COUNT_BITS-1:0]    r_count, n_count;
    logic [lfu_pkg::RANK_BITS-1:0]     r_rank, n_rank;
    lfu_pkg::t_cand                    r_cand, n_cand;
    logic                              sel;
    logic                              better;

    assign sel = (i_index == i_cmd.idx);

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_count = r_count;
        n_rank  = r_rank;
        case (i_cmd.op)
            lfu_pkg::OP_HIT: begin
                if (sel) begin
                    if (r_count != lfu_pkg::COUNT_MAX) begin
                        n_count = r_count + lfu_pkg::COUNT_BITS'(1);
                    end
                    n_rank = '0;
                end else if (r_valid && (r_rank < i_cmd.rank)) begin
                    n_rank = r_rank + lfu_pkg::RANK_BITS'(1);
                end
            end
            lfu_pkg::OP_INSERT, lfu_pkg::OP_REPLACE: begin
                if (sel) begin
                    n_valid = 1'b1;
                    n_tag   = i_cmd.key;
                    n_count = lfu_pkg::COUNT_BITS'(1);
                    n_rank  = '0;
                end else if (r_valid) begin
                    // On replacement, entries older than the victim keep their rank:
                    // they close the gap and are pushed back again by the new word.
                    if ((i_cmd.op == lfu_pkg::OP_INSERT) || !(r_rank > i_cmd.rank)) begin
                        n_rank = r_rank + lfu_pkg::RANK_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign better = r_valid && (!i_cand.found || (r_count < i_cand.count) ||
                    ((r_count == i_cand.count) && (r_rank > i_cand.rank)));

    always_comb begin
        n_cand = i_cand;
        if (better) begin
            n_cand.found = 1'b1;
            n_cand.idx   = i_index;
            n_cand.count = r_count;
            n_cand.rank  = r_rank;
            n_cand.tag   = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_rank  <= '0;
            r_cand  <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_rank  <= n_rank;
            r_cand  <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_cand       = r_cand;
    assign o_stat.valid = r_valid;
    assign o_stat.match = r_valid && (r_tag == i_cmd.key);
    assign o_stat.count = r_count;
    assign o_stat.rank  = r_rank;

endmodule

@@ hw/rtl/lfu_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_row
// Row of entry cells with the hit, free slot and victim results gathered.
// ----------------------------------------------------------------------------
module lfu_row (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lfu_pkg::t_cmd                    i_cmd,
    output logic                             o_hit,
    output logic [lfu_pkg::SLOT_BITS-1:0]    o_hit_idx,
    output logic [lfu_pkg::COUNT_BITS-1:0]   o_hit_count,
    output logic [lfu_pkg::RANK_BITS-1:0]    o_hit_rank,
    output logic [lfu_pkg::SLOT_BITS-1:0]    o_free_idx,
    output lfu_pkg::t_cand                   o_victim
);

    lfu_pkg::t_cand                    cand [lfu_pkg::ENTRIES+1];
    lfu_pkg::t_stat                    stat [lfu_pkg::ENTRIES];
    logic [lfu_pkg::ENTRIES-1:0]       valid_vec;
    logic [lfu_pkg::ENTRIES-1:0]       free_onehot;

    assign cand[0] = '0;

    genvar g;
    generate
        for (g = 0; g < lfu_pkg::ENTRIES; g++) begin : g_cell
            lfu_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (lfu_pkg::SLOT_BITS'(g)),
                .i_cmd   (i_cmd),
                .i_cand  (cand[g]),
                .o_cand  (cand[g+1]),
                .o_stat  (stat[g])
            );
            assign valid_vec[g] = stat[g].valid;
        end
    endgenerate

    // Lowest clear bit of the valid vector.
    assign free_onehot = ~valid_vec & (valid_vec + lfu_pkg::ENTRIES'(1));

    // Stored tags are unique, so at most one cell matches.
    always_comb begin
        o_hit       = 1'b0;
        o_hit_idx   = '0;
        o_hit_count = '0;
        o_hit_rank  = '0;
        o_free_idx  = '0;
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
            if (stat[i].match) begin
                o_hit       = 1'b1;
                o_hit_idx   = o_hit_idx | lfu_pkg::SLOT_BITS'(i);
                o_hit_count = o_hit_count | stat[i].count;
                o_hit_rank  = o_hit_rank | stat[i].rank;
            end
            if (free_onehot[i]) begin
                o_free_idx = o_free_idx | lfu_pkg::SLOT_BITS'(i);
            end
        end
    end

    assign o_victim = cand[lfu_pkg::ENTRIES];

endmodule

@@ hw/rtl/lfu_cache_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_replacement_core
// Fully associative LFU tag store built from a row of entry cells.
// ----------------------------------------------------------------------------
// A hit or a miss with a free slot passes through the lookup, update and done
// states; a miss that evicts also runs the victim search first, and capacity 0
// goes straight to done. The victim search walks the cell chain one cell a cycle.
// One word is processed at a time: a new word is taken only once the previous
// result has been loaded into the output register.
// Reset empties every entry, clears occupancy and sets capacity to 8.
module lfu_cache_replacement_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]     i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lfu_pkg::KEY_BITS-1:0]     i_key,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_hit,
    output logic [lfu_pkg::COUNT_BITS-1:0]   o_use_count,
    output logic [lfu_pkg::SLOT_BITS-1:0]    o_slot,
    output logic                             o_evicted,
    output logic [lfu_pkg::KEY_BITS-1:0]     o_evicted_key
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                        r_state, n_state;
    logic [lfu_pkg::CAP_BITS-1:0]      r_capacity;
    logic [lfu_pkg::OCC_BITS-1:0]      r_occ, n_occ;
    logic [lfu_pkg::OCC_BITS-1:0]      r_cnt, n_cnt;
    logic [lfu_pkg::KEY_BITS-1:0]      r_key, n_key;
    lfu_pkg::t_op                      r_op, n_op;
    logic [lfu_pkg::SLOT_BITS-1:0]     r_idx, n_idx;
    logic [lfu_pkg::RANK_BITS-1:0]     r_rank, n_rank;
    logic                              r_res_hit, n_res_hit;
    logic [lfu_pkg::COUNT_BITS-1:0]    r_res_count, n_res_count;
    logic                              r_res_ev, n_res_ev;
    logic [lfu_pkg::KEY_BITS-1:0]      r_res_evkey, n_res_evkey;
    logic                              r_ovalid, n_ovalid;
    logic                              r_o_hit;
    logic [lfu_pkg::COUNT_BITS-1:0]    r_o_count;
    logic [lfu_pkg::SLOT_BITS-1:0]     r_o_slot;
    logic                              r_o_ev;
    logic [lfu_pkg::KEY_BITS-1:0]      r_o_evkey;

    lfu_pkg::t_cmd                     cmd;
    logic                              hit;
    logic [lfu_pkg::SLOT_BITS-1:0]     hit_idx;
    logic [lfu_pkg::COUNT_BITS-1:0]    hit_count;
    logic [lfu_pkg::RANK_BITS-1:0]     hit_rank;
    logic [lfu_pkg::SLOT_BITS-1:0]     free_idx;
    lfu_pkg::t_cand                    victim;
    logic [lfu_pkg::CMP_BITS-1:0]      cap_ext;
    logic [lfu_pkg::CMP_BITS-1:0]      cap_eff;
    logic                              full;
    logic                              in_take;
    logic                              out_load;

    assign cap_ext = lfu_pkg::CMP_BITS'(r_capacity);
    assign cap_eff = (cap_ext > lfu_pkg::CMP_BITS'(lfu_pkg::ENTRIES)) ?
                     lfu_pkg::CMP_BITS'(lfu_pkg::ENTRIES) : cap_ext;
    assign full    = (lfu_pkg::CMP_BITS'(r_occ) >= cap_eff);

    assign cmd.op   = (r_state == S_APPLY) ? r_op : lfu_pkg::OP_NONE;
    assign cmd.idx  = r_idx;
    assign cmd.rank = r_rank;
    assign cmd.key  = r_key;

    lfu_row u_row (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_hit       (hit),
        .o_hit_idx   (hit_idx),
        .o_hit_count (hit_count),
        .o_hit_rank  (hit_rank),
        .o_free_idx  (free_idx),
        .o_victim    (victim)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign in_take  = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_op        = r_op;
        n_idx       = r_idx;
        n_rank      = r_rank;
        n_res_hit   = r_res_hit;
        n_res_count = r_res_count;
        n_res_ev    = r_res_ev;
        n_res_evkey = r_res_evkey;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_key       = i_key;
                    n_res_hit   = 1'b0;
                    n_res_count = '0;
                    n_res_ev    = 1'b0;
                    n_res_evkey = '0;
                    n_idx       = '0;
                    n_state     = (cap_eff == '0) ? S_DONE : S_LOOK;
                end
            end
            S_LOOK: begin
                if (hit) begin
                    n_op        = lfu_pkg::OP_HIT;
                    n_idx       = hit_idx;
                    n_rank      = hit_rank;
                    n_res_hit   = 1'b1;
                    n_res_count = (hit_count == lfu_pkg::COUNT_MAX) ?
                                  hit_count : hit_count + lfu_pkg::COUNT_BITS'(1);
                    n_state     = S_APPLY;
                end else if (full) begin
                    n_cnt   = '0;
                    n_state = S_SEARCH;
                end else begin
                    n_op        = lfu_pkg::OP_INSERT;
                    n_idx       = free_idx;
                    n_res_count = lfu_pkg::COUNT_BITS'(1);
                    n_state     = S_APPLY;
                end
            end
            S_SEARCH: begin
                // The search waits for the candidate to pass every cell register.
                if (r_cnt == lfu_pkg::OCC_BITS'(lfu_pkg::ENTRIES)) begin
                    n_op        = lfu_pkg::OP_REPLACE;
                    n_idx       = victim.idx;
                    n_rank      = victim.rank;
                    n_res_count = lfu_pkg::COUNT_BITS'(1);
                    n_res_ev    = 1'b1;
                    n_res_evkey = victim.tag;
                    n_state     = S_APPLY;
                end else begin
                    n_cnt = r_cnt + lfu_pkg::OCC_BITS'(1);
                end
            end
            S_APPLY: begin
                if (r_op == lfu_pkg::OP_INSERT) begin
                    n_occ = r_occ + lfu_pkg::OCC_BITS'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = out_load || (r_ovalid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_capacity <= lfu_pkg::CAP_RESET;
            r_occ      <= '0;
            r_cnt      <= '0;
            r_op       <= lfu_pkg::OP_NONE;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_cnt    <= n_cnt;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_idx       <= n_idx;
        r_rank      <= n_rank;
        r_res_hit   <= n_res_hit;
        r_res_count <= n_res_count;
        r_res_ev    <= n_res_ev;
        r_res_evkey <= n_res_evkey;
        if (out_load) begin
            r_o_hit   <= r_res_hit;
            r_o_count <= r_res_count;
            r_o_slot  <= r_idx;
            r_o_ev    <= r_res_ev;
            r_o_evkey <= r_res_evkey;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_hit         = r_o_hit;
    assign o_use_count   = r_o_count;
    assign o_slot        = r_o_slot;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_evkey;

endmodule

@@ sim/lfu_tag_store_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_tag_store_checker
// Follows the key and result channels of the LFU tag store and the capacity
// register port. Every accepted key word runs through a model of the store,
// and the prediction is queued. Each result word is compared field by field
// with the oldest queued prediction.
// ----------------------------------------------------------------------------
module lfu_tag_store_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]   i_cfg_data,
    input  logic                           i_key_valid,
    input  logic                           i_key_ready,
    input  logic [lfu_pkg::KEY_BITS-1:0]   i_key,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic                           i_hit,
    input  logic [lfu_pkg::COUNT_BITS-1:0] i_use_count,
    input  logic [lfu_pkg::SLOT_BITS-1:0]  i_slot,
    input  logic                           i_evicted,
    input  logic [lfu_pkg::KEY_BITS-1:0]   i_evicted_key,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic                           hit;
        logic [lfu_pkg::COUNT_BITS-1:0] use_count;
        logic [lfu_pkg::SLOT_BITS-1:0]  slot;
        logic                           evicted;
        logic [lfu_pkg::KEY_BITS-1:0]   evicted_key;
    } t_lookup;

    // Model of the store: rank 0 is the most recently accessed live entry.
    logic                           stored     [lfu_pkg::ENTRIES];
    logic [lfu_pkg::KEY_BITS-1:0]   stored_tag [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] use_cnt    [lfu_pkg::ENTRIES];
    int unsigned                    age_rank   [lfu_pkg::ENTRIES];
    int unsigned                    fill;
    logic [lfu_pkg::CAP_BITS-1:0]   cap_setting;

    t_lookup expected_lookups[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Looks one key up in the model, updates it and returns the result word.
    function automatic t_lookup lookup_key(input logic [lfu_pkg::KEY_BITS-1:0] key);
        t_lookup     res;
        int          limit;
        int          s;
        int          v;
        int unsigned r;
        res = '0;
        s = -1;
        v = -1;
        limit = (cap_setting > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(cap_setting);
        if (limit == 0)
            return res;

        for (int i = 0; i < lfu_pkg::ENTRIES; i++)
            if (s < 0 && stored[i] && stored_tag[i] == key)
                s = i;

        if (s >= 0) begin
            res.hit = 1'b1;
            if (use_cnt[s] != lfu_pkg::COUNT_MAX)
                use_cnt[s] = use_cnt[s] + 1'b1;
            r = age_rank[s];
            for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                if (stored[i] && i != s && age_rank[i] < r)
                    age_rank[i]++;
            age_rank[s] = 0;
        end else begin
            if (fill >= limit) begin
                // Lowest count goes; on a tie the entry touched longest ago.
                for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                    if (stored[i] && (v < 0 || use_cnt[i] < use_cnt[v] ||
                        (use_cnt[i] == use_cnt[v] && age_rank[i] > age_rank[v])))
                        v = i;
                end
                if (v >= 0) begin
                    r = age_rank[v];
                    res.evicted     = 1'b1;
                    res.evicted_key = stored_tag[v];
                    stored[v]   = 1'b0;
                    use_cnt[v]  = '0;
                    age_rank[v] = 0;
                    for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                        if (stored[i] && age_rank[i] > r)
                            age_rank[i]--;
                    if (fill > 0)
                        fill--;
                    s = v;
                end
            end
            if (s < 0)
                for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                    if (s < 0 && !stored[i])
                        s = i;
            if (s >= 0) begin
                for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                    if (stored[i])
                        age_rank[i]++;
                stored[s]     = 1'b1;
                stored_tag[s] = key;
                use_cnt[s]    = lfu_pkg::COUNT_BITS'(1);
                age_rank[s]   = 0;
                fill++;
            end
        end

        if (s >= 0) begin
            res.use_count = use_cnt[s];
            res.slot      = lfu_pkg::SLOT_BITS'(s);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup got;
        t_lookup want;
        if (!i_rst_n) begin
            for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
                stored[i]     = 1'b0;
                stored_tag[i] = '0;
                use_cnt[i]    = '0;
                age_rank[i]   = 0;
            end
            fill        = 0;
            cap_setting = lfu_pkg::CAP_RESET;
            expected_lookups.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_we)
                cap_setting = i_cfg_data;

            if (i_res_valid && i_res_ready) begin
                got = {i_hit, i_use_count, i_slot, i_evicted, i_evicted_key};
                if (expected_lookups.size() == 0) begin
                    report_mismatch($sformatf("result word 0x%0h with no lookup pending",
                                              got));
                end else begin
                    want = expected_lookups[0];
                    expected_lookups.delete(0);
                    check_field("hit", 64'(got.hit), 64'(want.hit));
                    check_field("use_count", 64'(got.use_count), 64'(want.use_count));
                    check_field("slot", 64'(got.slot), 64'(want.slot));
                    check_field("evicted", 64'(got.evicted), 64'(want.evicted));
                    check_field("evicted_key", 64'(got.evicted_key),
                                64'(want.evicted_key));
                end
            end

            if (i_key_valid && i_key_ready)
                expected_lookups.insert(expected_lookups.size(), lookup_key(i_key));

            o_outstanding <= expected_lookups.size();
        end
    end

endmodule

@@ sim/lfu_cache_replacement_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_replacement_core_tb
// Drives key words into the LFU tag store under random source gaps and sink
// stalls, steps the capacity register through its range between phases and
// leaves all result checking to the checker beside the block.
// ----------------------------------------------------------------------------
module lfu_cache_replacement_core_tb;

    localparam int PHASES         = 11;
    localparam int PHASE_ITEMS    = 48;
    localparam int HOT_REPEATS    = 4;
    localparam int POOL_MAX       = lfu_pkg::ENTRIES + 4;
    localparam int SETTLE_CYCLES  = lfu_pkg::ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [lfu_pkg::KEY_BITS-1:0] HOT_KEY = 32'h1234_5678;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [lfu_pkg::CAP_BITS-1:0]   i_cfg_data = '0;
    logic                           i_valid    = 1'b0;
    logic [lfu_pkg::KEY_BITS-1:0]   i_key      = '0;
    logic                           i_ready    = 1'b0;
    logic                           o_ready;
    logic                           o_valid;
    logic                           o_hit;
    logic [lfu_pkg::COUNT_BITS-1:0] o_use_count;
    logic [lfu_pkg::SLOT_BITS-1:0]  o_slot;
    logic                           o_evicted;
    logic [lfu_pkg::KEY_BITS-1:0]   o_evicted_key;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int rx_hold     = 0;
    int rx_roll;
    bit rx_steady   = 1'b1;
    bit tx_steady   = 1'b1;

    logic [lfu_pkg::CAP_BITS-1:0] cap_first [6] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd5};

    always #5 i_clk = ~i_clk;

    lfu_cache_replacement_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_use_count   (o_use_count),
        .o_slot        (o_slot),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    lfu_tag_store_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_key_valid   (i_valid),
        .i_key_ready   (o_ready),
        .i_key         (i_key),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_hit         (o_hit),
        .i_use_count   (o_use_count),
        .i_slot        (o_slot),
        .i_evicted     (o_evicted),
        .i_evicted_key (o_evicted_key),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Result sink: mostly short stalls, now and then a long one.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_steady) begin
            i_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 60) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_hold <= (rx_roll < 93) ? $urandom_range(0, 3) : $urandom_range(8, 30);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Valid stays high across back-to-back words; it only drops for a gap.
    task automatic send_key(input logic [lfu_pkg::KEY_BITS-1:0] key);
        int gap;
        int roll;
        gap = 0;
        if (!tx_steady) begin
            roll = $urandom_range(0, 99);
            if (roll >= 55)
                gap = (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic settle_store();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lfu_pkg::CAP_BITS-1:0] value);
        settle_store();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A small pool of keys keeps hits and evictions frequent; taking the
    // smaller of two indices skews the use counts so that they spread out.
    task automatic run_random_phase(input logic [lfu_pkg::CAP_BITS-1:0] cap,
                                    input bit steady);
        logic [lfu_pkg::KEY_BITS-1:0] pool [POOL_MAX];
        int pool_len;
        int a;
        int b;
        write_capacity(cap);
        tx_steady = steady;
        rx_steady <= steady;
        pool_len = ((cap > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : int'(cap)) +
                   $urandom_range(1, 4);
        foreach (pool[i])
            pool[i] = $urandom();
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 90) begin
                a = $urandom_range(0, pool_len - 1);
                b = $urandom_range(0, pool_len - 1);
                send_key(pool[(a < b) ? a : b]);
            end else begin
                send_key($urandom());
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the store from empty, then force an eviction by frequency.
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h0000_0000);
        for (int k = 1; k <= 6; k++)
            send_key(lfu_pkg::KEY_BITS'(k));
        send_key(32'hA5A5_A5A5);
        send_key(32'h0000_0003);
        send_key(32'h0000_0003);

        // A disabled store answers with an all-zero word.
        write_capacity(4'd0);
        send_key(32'h0000_0000);

        // Settings above the number of entries are clamped to the number of entries.
        write_capacity(4'd15);
        send_key(32'h5A5A_5A5A);

        // Shrinking below the occupancy: each miss evicts exactly one entry.
        write_capacity(4'd3);
        send_key(32'h0000_0100);
        send_key(32'h0000_0200);
        send_key(32'h0000_0300);
        send_key(32'h0000_0300);

        write_capacity(4'd1);
        send_key(32'h0000_0400);
        send_key(32'h0000_0400);
        send_key(32'h0000_0500);

        // Give one key a high use count, then check that it survives misses
        // at a small capacity and still hits.
        write_capacity(4'd8);
        repeat (HOT_REPEATS)
            send_key(HOT_KEY);
        write_capacity(4'd2);
        send_key(32'hC0DE_0001);
        send_key(32'hC0DE_0002);
        send_key(HOT_KEY);

        for (int phase = 0; phase < PHASES; phase++)
            run_random_phase((phase < 6) ? cap_first[phase] :
                             lfu_pkg::CAP_BITS'($urandom_range(0, 15)),
                             (phase % 4) == 0);

        settle_store();
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ lfu_cache_replacement_core.f @@
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_row.sv
hw/rtl/lfu_cache_replacement_core.sv
sim/lfu_tag_store_checker.sv
sim/lfu_cache_replacement_core_tb.sv
